### sv/psp_link_pkg.sv
// Shared types and constants for the pulse serial parity link.
`timescale 1ns / 1ps

package psp_link_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 8;
    localparam int TickW = 8;
    localparam int ByteW = 8;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_START_PULSE_TICKS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BIT_TICKS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_CHECK_TICKS = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_CHECK_TICKS = 2'd3;

    // Register values after reset
    localparam logic [TickW-1:0] RST_START_PULSE_TICKS = 8'd10;
    localparam logic [TickW-1:0] RST_BIT_TICKS = 8'd5;
    localparam logic [TickW-1:0] RST_FIRST_CHECK_TICKS = 8'd2;
    localparam logic [TickW-1:0] RST_SECOND_CHECK_TICKS = 8'd5;

    localparam logic [TickW-1:0] TICK_ONE = 8'h01;

    typedef enum logic [3:0] {
        TX_IDLE  = 4'b0001,
        TX_START = 4'b0010,
        TX_DATA  = 4'b0100,
        TX_PAR   = 4'b1000
    } t_tx_phase;

    typedef enum logic [4:0] {
        RX_IDLE   = 5'b00001,
        RX_CHECK1 = 5'b00010,
        RX_CHECK2 = 5'b00100,
        RX_DATA   = 5'b01000,
        RX_PAR    = 5'b10000
    } t_rx_phase;

    typedef struct packed {
        logic             tx_level;
        logic             tx_busy;
        logic             rx_valid;
        logic [ByteW-1:0] rx_byte;
        logic             rx_parity_error;
    } t_result;

endpackage

### sv/pulse_serial_parity_link_core.sv
// Top level of the pulse serial parity link: timed transmitter, checked receiver.
`timescale 1ns / 1ps
// A result is registered in the result register, or in the skid entry while the result register is stalled.
// Throughput: one item per cycle while o_stall is low; the state update is a single registered pass
// (tick counter add and compare, shift), and a one-entry skid stage lets the
// block take one more item while the result register is stalled.
// Reset (i_rst_n low, synchronous): both link sides go idle, counters and shift
// registers clear, the tick registers return to their defaults, no result pends.

module pulse_serial_parity_link_core
    import psp_link_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_cmd,
    input  logic [ByteW-1:0]    i_send_byte,
    input  logic                i_rx_level,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_tx_level,
    output logic                o_tx_busy,
    output logic                o_rx_valid,
    output logic [ByteW-1:0]    o_rx_byte,
    output logic                o_rx_parity_error
);

    // Bit index must be able to hold DATA_BITS itself.
    localparam int BitIdxW = $clog2(DATA_BITS + 1);
    localparam logic [BitIdxW-1:0] LastBitIdx = BitIdxW'(DATA_BITS - 1);
    localparam logic [BitIdxW-1:0] AllBitsIdx = BitIdxW'(DATA_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TickW-1:0] r_start_pulse_ticks;
    logic [TickW-1:0] r_bit_ticks;
    logic [TickW-1:0] r_first_check_ticks;
    logic [TickW-1:0] r_second_check_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pulse_ticks  <= RST_START_PULSE_TICKS;
            r_bit_ticks          <= RST_BIT_TICKS;
            r_first_check_ticks  <= RST_FIRST_CHECK_TICKS;
            r_second_check_ticks <= RST_SECOND_CHECK_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_PULSE_TICKS:  r_start_pulse_ticks  <= i_cfg_data;
                CFG_BIT_TICKS:          r_bit_ticks          <= i_cfg_data;
                CFG_FIRST_CHECK_TICKS:  r_first_check_ticks  <= i_cfg_data;
                CFG_SECOND_CHECK_TICKS: r_second_check_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Link state
    // ------------------------------------------------------------------
    t_tx_phase              r_tx_phase, n_tx_phase;
    logic [DATA_BITS-1:0]   r_tx_shift, n_tx_shift;   // current bit sits at the MSB
    logic [BitIdxW-1:0]     r_tx_bit_idx, n_tx_bit_idx;
    logic [TickW-1:0]       r_tx_cnt, n_tx_cnt;
    logic                   r_tx_parity, n_tx_parity;

    t_rx_phase              r_rx_phase, n_rx_phase;
    logic [TickW-1:0]       r_rx_cnt, n_rx_cnt;
    logic [BitIdxW-1:0]     r_rx_bit_idx, n_rx_bit_idx;
    logic [DATA_BITS-1:0]   r_rx_shift, n_rx_shift;
    logic                   r_rx_parity, n_rx_parity;

    // Handshake
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result n_result;
    logic    in_fire;
    logic    out_fire;

    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;

    logic [DATA_BITS-1:0] send_word;
    logic [TickW-1:0]     tx_cnt_inc;
    logic [TickW-1:0]     rx_cnt_inc;

    assign send_word  = DATA_BITS'(i_send_byte);
    assign tx_cnt_inc = r_tx_cnt + TICK_ONE;
    assign rx_cnt_inc = r_rx_cnt + TICK_ONE;

    // Next state and result of one item
    always_comb begin
        n_tx_phase   = r_tx_phase;
        n_tx_shift   = r_tx_shift;
        n_tx_bit_idx = r_tx_bit_idx;
        n_tx_cnt     = r_tx_cnt;
        n_tx_parity  = r_tx_parity;
        n_rx_phase   = r_rx_phase;
        n_rx_cnt     = r_rx_cnt;
        n_rx_bit_idx = r_rx_bit_idx;
        n_rx_shift   = r_rx_shift;
        n_rx_parity  = r_rx_parity;
        n_result     = '0;

        if (i_cmd) begin
            // Send request: start the frame at once, drop it if busy.
            if (r_tx_phase == TX_IDLE) begin
                n_tx_phase   = TX_START;
                n_tx_shift   = send_word;
                n_tx_bit_idx = '0;
                n_tx_cnt     = '0;
                n_tx_parity  = ^send_word;
            end
        end else begin
            // Transmit side advances one tick.
            case (r_tx_phase)
                TX_START: begin
                    n_tx_cnt = tx_cnt_inc;
                    if (tx_cnt_inc >= r_start_pulse_ticks) begin
                        n_tx_phase   = TX_DATA;
                        n_tx_bit_idx = '0;
                        n_tx_cnt     = '0;
                    end
                end
                TX_DATA: begin
                    n_tx_cnt = tx_cnt_inc;
                    if (tx_cnt_inc >= r_bit_ticks) begin
                        n_tx_cnt     = '0;
                        n_tx_shift   = r_tx_shift << 1;
                        n_tx_bit_idx = r_tx_bit_idx + 1'b1;
                        if (r_tx_bit_idx == LastBitIdx) begin
                            n_tx_phase = TX_PAR;
                        end
                    end
                end
                TX_PAR: begin
                    n_tx_cnt = tx_cnt_inc;
                    if (tx_cnt_inc >= r_bit_ticks) begin
                        n_tx_phase   = TX_IDLE;
                        n_tx_cnt     = '0;
                        n_tx_bit_idx = '0;
                    end
                end
                default: ;
            endcase

            // Receive side samples the line.
            case (r_rx_phase)
                RX_IDLE: begin
                    if (i_rx_level) begin
                        n_rx_phase = RX_CHECK1;
                        n_rx_cnt   = '0;
                    end
                end
                RX_CHECK1: begin
                    n_rx_cnt = rx_cnt_inc;
                    if (rx_cnt_inc >= r_first_check_ticks) begin
                        n_rx_cnt   = '0;
                        n_rx_phase = i_rx_level ? RX_CHECK2 : RX_IDLE;
                    end
                end
                RX_CHECK2: begin
                    n_rx_cnt = rx_cnt_inc;
                    if (rx_cnt_inc >= r_second_check_ticks) begin
                        n_rx_cnt = '0;
                        if (i_rx_level) begin
                            n_rx_phase   = RX_DATA;
                            n_rx_bit_idx = '0;
                            n_rx_parity  = 1'b0;
                            n_rx_shift   = '0;
                        end else begin
                            // failed start check: go back to listening
                            n_rx_phase = RX_IDLE;
                        end
                    end
                end
                RX_DATA: begin
                    n_rx_cnt = rx_cnt_inc;
                    if (rx_cnt_inc >= r_bit_ticks) begin
                        n_rx_cnt     = '0;
                        n_rx_shift   = (r_rx_shift << 1) | DATA_BITS'(i_rx_level);
                        n_rx_parity  = r_rx_parity ^ i_rx_level;
                        n_rx_bit_idx = r_rx_bit_idx + 1'b1;
                        if (r_rx_bit_idx == LastBitIdx) begin
                            n_rx_phase = RX_PAR;
                        end
                    end
                end
                RX_PAR: begin
                    n_rx_cnt = rx_cnt_inc;
                    if (rx_cnt_inc >= r_bit_ticks) begin
                        n_rx_cnt                 = '0;
                        n_result.rx_valid        = 1'b1;
                        n_result.rx_byte         = ByteW'(r_rx_shift);
                        n_result.rx_parity_error = r_rx_parity ^ i_rx_level;
                        n_rx_phase               = RX_IDLE;
                        n_rx_bit_idx             = '0;
                    end
                end
                default: ;
            endcase
        end

        // Line level after this item
        case (n_tx_phase)
            TX_START: n_result.tx_level = 1'b1;
            TX_DATA:  n_result.tx_level = n_tx_shift[DATA_BITS-1];
            TX_PAR:   n_result.tx_level = n_tx_parity;
            default:  n_result.tx_level = 1'b0;
        endcase
        n_result.tx_busy = (n_tx_phase != TX_IDLE);
    end

    // Advance state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_phase   <= TX_IDLE;
            r_tx_shift   <= '0;
            r_tx_bit_idx <= '0;
            r_tx_cnt     <= '0;
            r_tx_parity  <= 1'b0;
            r_rx_phase   <= RX_IDLE;
            r_rx_cnt     <= '0;
            r_rx_bit_idx <= '0;
            r_rx_shift   <= '0;
            r_rx_parity  <= 1'b0;
        end else if (in_fire) begin
            r_tx_phase   <= n_tx_phase;
            r_tx_shift   <= n_tx_shift;
            r_tx_bit_idx <= n_tx_bit_idx;
            r_tx_cnt     <= n_tx_cnt;
            r_tx_parity  <= n_tx_parity;
            r_rx_phase   <= n_rx_phase;
            r_rx_cnt     <= n_rx_cnt;
            r_rx_bit_idx <= n_rx_bit_idx;
            r_rx_shift   <= n_rx_shift;
            r_rx_parity  <= n_rx_parity;
        end
    end

    // Result register plus skid entry; the skid only fills when the result
    // register is held by a stall while a new item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (r_out_valid && !out_fire) begin
                    r_skid_valid <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_tx_level        = r_out.tx_level;
    assign o_tx_busy         = r_out.tx_busy;
    assign o_rx_valid        = r_out.rx_valid;
    assign o_rx_byte         = r_out.rx_byte;
    assign o_rx_parity_error = r_out.rx_parity_error;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the result register is empty");

    a_stalled_take_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("item taken under stall was not parked in the skid entry");

    a_idle_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tx_busy) |-> !o_tx_level)
        else $error("transmit line high while transmitter idle");

    a_rx_par_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_phase == RX_PAR) |-> (r_rx_bit_idx == AllBitsIdx))
        else $error("receiver reached parity bit without all data bits");

endmodule
